[hdl/spi_pkg.sv]
// Shared types and constants for the segment versus plane intersection block.
// Used by every module under hdl; depends on nothing else.
package spi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	// Fraction bits of the crossing ratio; one quotient bit is resolved per stage.
	localparam int QBITS           = 62;
	localparam int CFG_INDEX_BITS  = 2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_X = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_Y = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_Z = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET   = 2'd3;

	localparam logic [1:0] ST_CROSS    = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_NONE     = 2'd2;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_AB   = 2'b01;
	localparam logic [1:0] DIR_BA   = 2'b11;

	localparam logic [1:0] MASK_NONE = 2'b00;
	localparam logic [1:0] MASK_A    = 2'b01;
	localparam logic [1:0] MASK_B    = 2'b10;
	localparam logic [1:0] MASK_BOTH = 2'b11;

	typedef enum logic [1:0] {
		PT_ZERO  = 2'd0,
		PT_A     = 2'd1,
		PT_B     = 2'd2,
		PT_CROSS = 2'd3
	} pt_sel_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] dir;
		logic [1:0] mask;
		pt_sel_t    psel;
	} ctrl_t;

endpackage

[hdl/spi_front.sv]
// Front end: plane side values, segment deltas and squared lengths, and case
// classification over three pipeline stages. Depends on spi_pkg.
module spi_front #(
	parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  logic [2:0][COORD_WIDTH-1:0]         pa,
	input  logic [2:0][COORD_WIDTH-1:0]         pb,
	input  logic [2:0][COORD_WIDTH-1:0]         normal,
	input  logic [COORD_WIDTH-1:0]              offset,
	output logic                                v_s3,
	output logic [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
		2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+1:0]  num_s3,
	output logic [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
		2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+2:0]  den_s3,
	output logic [2*COORD_WIDTH+1:0]            len2_s3,
	output logic [6*COORD_WIDTH+3+$bits(spi_pkg::ctrl_t)-1:0] pay_s3
);
	import spi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int SW = ((2*W > W+FRAC_BITS) ? 2*W : W+FRAC_BITS) + 2;

	logic                        v_s1;
	logic signed [2*W-1:0]       prod_a_s1 [3];
	logic signed [2*W-1:0]       prod_b_s1 [3];
	logic signed [W:0]           d_s1 [3];
	logic [2:0][W-1:0]           a_s1;
	logic                        eq_s1;

	logic                        v_s2;
	logic signed [SW-1:0]        sa_s2;
	logic signed [SW-1:0]        sb_s2;
	logic [2*W+1:0]              sq_s2 [3];
	logic signed [W:0]           d_s2 [3];
	logic [2:0][W-1:0]           a_s2;
	logic                        eq_s2;

	logic signed [SW-1:0]        dterm;
	logic [SW-1:0]               mag_a;
	logic [SW-1:0]               mag_b;
	logic                        a_ge;
	logic                        b_ge;
	ctrl_t                       ctrl_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_a_s1[i] <= $signed(pa[i]) * $signed(normal[i]);
				prod_b_s1[i] <= $signed(pb[i]) * $signed(normal[i]);
				d_s1[i] <= $signed({pb[i][W-1], pb[i]}) - $signed({pa[i][W-1], pa[i]});
			end
			a_s1  <= pa;
			eq_s1 <= (pa == pb);
		end
	end

	assign dterm = SW'($signed(offset)) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s2 <= SW'(prod_a_s1[0]) + SW'(prod_a_s1[1]) + SW'(prod_a_s1[2]) + dterm;
			sb_s2 <= SW'(prod_b_s1[0]) + SW'(prod_b_s1[1]) + SW'(prod_b_s1[2]) + dterm;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= d_s1[i] * d_s1[i];
				d_s2[i]  <= d_s1[i];
			end
			a_s2  <= a_s1;
			eq_s2 <= eq_s1;
		end
	end

	assign mag_a = sa_s2[SW-1] ? SW'(-sa_s2) : SW'(sa_s2);
	assign mag_b = sb_s2[SW-1] ? SW'(-sb_s2) : SW'(sb_s2);
	assign a_ge  = !sa_s2[SW-1];
	assign b_ge  = !sb_s2[SW-1];

	always_comb begin
		ctrl_c.status = ST_NONE;
		ctrl_c.dir    = DIR_NONE;
		ctrl_c.mask   = MASK_NONE;
		ctrl_c.psel   = PT_ZERO;
		if (eq_s2) begin
			// A zero-length segment reports only the point itself, or zero below the plane.
			ctrl_c.mask   = a_ge ? MASK_BOTH : MASK_NONE;
			ctrl_c.psel   = a_ge ? PT_A : PT_ZERO;
			ctrl_c.status = (sa_s2 == '0) ? ST_CROSS : ST_PARALLEL;
		end else begin
			ctrl_c.mask = {b_ge, a_ge};
			if (ctrl_c.mask == MASK_NONE || ctrl_c.mask == MASK_BOTH) begin
				ctrl_c.status = ST_NONE;
			end else if (sa_s2 == '0) begin
				ctrl_c.status = ST_CROSS;
				ctrl_c.dir    = DIR_AB;
				ctrl_c.psel   = PT_A;
			end else if (sb_s2 == '0) begin
				ctrl_c.status = ST_CROSS;
				ctrl_c.dir    = DIR_BA;
				ctrl_c.psel   = PT_B;
			end else begin
				ctrl_c.status = ST_CROSS;
				ctrl_c.dir    = DIR_AB;
				ctrl_c.psel   = PT_CROSS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= mag_a;
			den_s3  <= (SW+1)'(mag_a) + (SW+1)'(mag_b);
			len2_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			pay_s3  <= {ctrl_c, d_s2[2], d_s2[1], d_s2[0], a_s2};
		end
	end

endmodule

[hdl/spi_iter.sv]
// Iterative core: one restoring quotient bit per stage for the crossing ratio,
// with the integer square root of the squared length in the first stages.
// Depends on spi_pkg.
module spi_iter #(
	parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  logic [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
		2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+1:0]  num,
	input  logic [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
		2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+2:0]  den,
	input  logic [2*COORD_WIDTH+1:0]            len2,
	input  logic [6*COORD_WIDTH+3+$bits(spi_pkg::ctrl_t)-1:0] pay,
	output logic                                out_v,
	output logic [spi_pkg::QBITS-1:0]           fq,
	output logic [COORD_WIDTH:0]                root,
	output logic [6*COORD_WIDTH+3+$bits(spi_pkg::ctrl_t)-1:0] out_pay
);
	import spi_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int SW  = ((2*W > W+FRAC_BITS) ? 2*W : W+FRAC_BITS) + 2;
	localparam int RW  = SW + 1;
	localparam int RB  = W + 1;
	localparam int LW  = 2 * RB;
	localparam int SQW = RB + 3;
	localparam int QB  = QBITS;
	localparam int PW  = 6*W + 3 + $bits(ctrl_t);

	logic             v_s    [QB];
	logic [RW-1:0]    rem_s  [QB];
	logic [RW-1:0]    den_s  [QB];
	logic [QB-1:0]    q_s    [QB];
	logic [LW-1:0]    sqn_s  [QB];
	logic [SQW-1:0]   sqr_s  [QB];
	logic [RB-1:0]    root_s [QB];
	logic [PW-1:0]    pay_s  [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic           v_i;
		logic [RW-1:0]  rem_i;
		logic [RW-1:0]  den_i;
		logic [QB-1:0]  q_i;
		logic [LW-1:0]  sqn_i;
		logic [SQW-1:0] sqr_i;
		logic [RB-1:0]  root_i;
		logic [PW-1:0]  pay_i;
		logic [RW-1:0]  sh;
		logic           qbit;
		logic [LW-1:0]  sqn_n;
		logic [SQW-1:0] sqr_n;
		logic [RB-1:0]  root_n;

		if (k == 0) begin : g_src
			assign v_i    = in_v;
			assign rem_i  = RW'(num);
			assign den_i  = den;
			assign q_i    = '0;
			assign sqn_i  = len2;
			assign sqr_i  = '0;
			assign root_i = '0;
			assign pay_i  = pay;
		end else begin : g_src
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign den_i  = den_s[k-1];
			assign q_i    = q_s[k-1];
			assign sqn_i  = sqn_s[k-1];
			assign sqr_i  = sqr_s[k-1];
			assign root_i = root_s[k-1];
			assign pay_i  = pay_s[k-1];
		end

		assign sh   = rem_i << 1;
		assign qbit = (sh >= den_i);

		if (k < RB) begin : g_sqrt
			logic [SQW-1:0] t;
			logic [SQW-1:0] trial;
			logic           take;
			// Bring down the next two radicand bits and try root*4+1.
			assign t      = {sqr_i[SQW-3:0], sqn_i[LW-1 -: 2]};
			assign trial  = SQW'({root_i, 2'b01});
			assign take   = (t >= trial);
			assign sqr_n  = take ? (t - trial) : t;
			assign root_n = {root_i[RB-2:0], take};
			assign sqn_n  = sqn_i << 2;
		end else begin : g_hold
			assign sqr_n  = sqr_i;
			assign root_n = root_i;
			assign sqn_n  = sqn_i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= qbit ? (sh - den_i) : sh;
				den_s[k]  <= den_i;
				q_s[k]    <= {q_i[QB-2:0], qbit};
				sqn_s[k]  <= sqn_n;
				sqr_s[k]  <= sqr_n;
				root_s[k] <= root_n;
				pay_s[k]  <= pay_i;
			end
		end
	end

	assign out_v   = v_s[QB-1];
	assign fq      = q_s[QB-1];
	assign root    = root_s[QB-1];
	assign out_pay = pay_s[QB-1];

endmodule

[hdl/spi_lerp.sv]
// Back end: scales the deltas and the length by the crossing ratio with split
// partial products, rounds, saturates and selects the result. Depends on spi_pkg.
module spi_lerp #(
	parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  logic [spi_pkg::QBITS-1:0]           fq,
	input  logic [COORD_WIDTH:0]                root,
	input  logic [6*COORD_WIDTH+3+$bits(spi_pkg::ctrl_t)-1:0] pay,
	output logic                                v_sf,
	output logic [1:0]                          status_sf,
	output logic [1:0]                          dir_sf,
	output logic [1:0]                          mask_sf,
	output logic [2:0][COORD_WIDTH-1:0]         pt_sf,
	output logic [COORD_WIDTH-2:0]              dist_sf
);
	import spi_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int QB  = QBITS;
	localparam int HB  = QB / 2;
	localparam int MW  = W + 1;
	localparam int FW  = W + QB + 2;
	localparam int AW  = 3 * W;
	localparam int PW  = 6*W + 3 + $bits(ctrl_t);

	logic [2:0][W-1:0]  a_i;
	logic [W:0]         d_i [3];
	ctrl_t              ctrl_i;
	logic [MW-1:0]      mag_c [4];

	logic               v_sm;
	logic [MW+HB-1:0]   pl_sm [4];
	logic [MW+QB-HB-1:0] ph_sm [4];
	logic [2:0]         neg_sm;
	logic [2:0][W-1:0]  a_sm;
	logic [2:0][W-1:0]  b_sm;
	ctrl_t              ctrl_sm;

	logic [FW-1:0]      full_c [4];
	logic [W+1:0]       off_c [4];
	logic [2:0][W-1:0]  cross_c;
	logic [W-2:0]       dist_c;

	assign a_i    = pay[AW-1:0];
	assign ctrl_i = ctrl_t'(pay[PW-1 -: $bits(ctrl_t)]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_i[i]   = pay[AW + i*(W+1) +: W+1];
			mag_c[i] = d_i[i][W] ? MW'(-d_i[i]) : MW'(d_i[i]);
		end
		mag_c[3] = root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
			v_sf <= 1'b0;
		end else if (en) begin
			v_sm <= in_v;
			v_sf <= v_sm;
		end
	end

	// The ratio is split in two halves so each multiplier stays narrow.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				pl_sm[i] <= mag_c[i] * fq[HB-1:0];
				ph_sm[i] <= mag_c[i] * fq[QB-1:HB];
			end
			for (int i = 0; i < 3; i++) begin
				neg_sm[i] <= d_i[i][W];
				b_sm[i]   <= a_i[i] + d_i[i][W-1:0];
			end
			a_sm    <= a_i;
			ctrl_sm <= ctrl_i;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			full_c[i] = (FW'(ph_sm[i]) << HB) + FW'(pl_sm[i]) + (FW'(1) << (QB-1));
			off_c[i]  = full_c[i][FW-1:QB];
		end
		for (int i = 0; i < 3; i++) begin
			cross_c[i] = a_sm[i] + (neg_sm[i] ? -off_c[i][W-1:0] : off_c[i][W-1:0]);
		end
		dist_c = (|off_c[3][W+1:W-1]) ? '1 : off_c[3][W-2:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_sf <= ctrl_sm.status;
			dir_sf    <= ctrl_sm.dir;
			mask_sf   <= ctrl_sm.mask;
			dist_sf   <= '0;
			case (ctrl_sm.psel)
				PT_A:     pt_sf <= a_sm;
				PT_B:     pt_sf <= b_sm;
				PT_CROSS: begin
					pt_sf   <= cross_c;
					dist_sf <= dist_c;
				end
				default:  pt_sf <= '0;
			endcase
		end
	end

endmodule

[hdl/segment_plane_intersect.sv]
// Segment versus plane intersection, fully pipelined.
// Throughput one segment per cycle while the output skid is empty. Depth is set
// by the crossing-ratio divider, which resolves one quotient bit per stage. A
// one-entry output skid takes the result that meets an output stall; while it
// holds one, in_stall is high and the pipeline holds. Reset clears all valid bits
// and the skid and loads the default plane z = 0 (normal 0, 0, 1.0 and offset 0).
module segment_plane_intersect #(
	parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = spi_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [spi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_WIDTH-1:0]       start_x,
	input  logic signed [COORD_WIDTH-1:0]       start_y,
	input  logic signed [COORD_WIDTH-1:0]       start_z,
	input  logic signed [COORD_WIDTH-1:0]       end_x,
	input  logic signed [COORD_WIDTH-1:0]       end_y,
	input  logic signed [COORD_WIDTH-1:0]       end_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [1:0]                   crossing_direction,
	output logic [1:0]                          side_mask,
	output logic signed [COORD_WIDTH-1:0]       cross_x,
	output logic signed [COORD_WIDTH-1:0]       cross_y,
	output logic signed [COORD_WIDTH-1:0]       cross_z,
	output logic [COORD_WIDTH-2:0]              distance_along
);
	import spi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int SW = ((2*W > W+FRAC_BITS) ? 2*W : W+FRAC_BITS) + 2;
	localparam int PW = 6*W + 3 + $bits(ctrl_t);

	logic [W-1:0]       normal_x_q;
	logic [W-1:0]       normal_y_q;
	logic [W-1:0]       normal_z_q;
	logic [W-1:0]       offset_q;

	logic               en;
	logic               v_s3;
	logic [SW-1:0]      num_s3;
	logic [SW:0]        den_s3;
	logic [2*W+1:0]     len2_s3;
	logic [PW-1:0]      pay_s3;

	logic               it_v;
	logic [QBITS-1:0]   it_fq;
	logic [W:0]         it_root;
	logic [PW-1:0]      it_pay;

	logic               fin_v;
	logic [1:0]         fin_status;
	logic [1:0]         fin_dir;
	logic [1:0]         fin_mask;
	logic [2:0][W-1:0]  fin_pt;
	logic [W-2:0]       fin_dist;

	logic               skid_v_q;
	logic [1:0]         skid_status_q;
	logic [1:0]         skid_dir_q;
	logic [1:0]         skid_mask_q;
	logic [2:0][W-1:0]  skid_pt_q;
	logic [W-2:0]       skid_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= '0;
			normal_y_q <= '0;
			normal_z_q <= W'(1) << FRAC_BITS;
			offset_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NORMAL_X: normal_x_q <= cfg_data;
				CFG_NORMAL_Y: normal_y_q <= cfg_data;
				CFG_NORMAL_Z: normal_z_q <= cfg_data;
				CFG_OFFSET:   offset_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	// The whole pipeline moves together unless the skid already holds a result.
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	spi_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_v          (in_valid),
		.pa            ({start_z, start_y, start_x}),
		.pb            ({end_z, end_y, end_x}),
		.normal        ({normal_z_q, normal_y_q, normal_x_q}),
		.offset        (offset_q),
		.v_s3          (v_s3),
		.num_s3        (num_s3),
		.den_s3        (den_s3),
		.len2_s3       (len2_s3),
		.pay_s3        (pay_s3)
	);

	spi_iter #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s3),
		.num    (num_s3),
		.den    (den_s3),
		.len2   (len2_s3),
		.pay    (pay_s3),
		.out_v  (it_v),
		.fq     (it_fq),
		.root   (it_root),
		.out_pay(it_pay)
	);

	spi_lerp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_lerp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (it_v),
		.fq       (it_fq),
		.root     (it_root),
		.pay      (it_pay),
		.v_sf     (fin_v),
		.status_sf(fin_status),
		.dir_sf   (fin_dir),
		.mask_sf  (fin_mask),
		.pt_sf    (fin_pt),
		.dist_sf  (fin_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_stall) begin
				skid_v_q <= 1'b0;
			end
		end else if (fin_v && out_stall) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && fin_v && out_stall) begin
			skid_status_q <= fin_status;
			skid_dir_q    <= fin_dir;
			skid_mask_q   <= fin_mask;
			skid_pt_q     <= fin_pt;
			skid_dist_q   <= fin_dist;
		end
	end

	assign out_valid          = skid_v_q || fin_v;
	assign status             = skid_v_q ? skid_status_q : fin_status;
	assign crossing_direction = skid_v_q ? skid_dir_q : fin_dir;
	assign side_mask          = skid_v_q ? skid_mask_q : fin_mask;
	assign cross_x            = skid_v_q ? skid_pt_q[0] : fin_pt[0];
	assign cross_y            = skid_v_q ? skid_pt_q[1] : fin_pt[1];
	assign cross_z            = skid_v_q ? skid_pt_q[2] : fin_pt[2];
	assign distance_along     = skid_v_q ? skid_dist_q : fin_dist;

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NONE |-> crossing_direction == DIR_NONE &&
		distance_along == '0)
		else $error("no-intersection result carries a direction or distance");

	a_ba_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crossing_direction == DIR_BA |-> side_mask == MASK_B)
		else $error("B to A crossing with wrong side mask");

	a_dist_cross: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && distance_along != '0 |-> status == ST_CROSS &&
		crossing_direction == DIR_AB)
		else $error("nonzero distance outside a strict crossing");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(fin_v && out_stall))
		else $error("skid filled without a stalled final result");

endmodule
